// ===== design/kbr_pkg.sv =====
// Package with shared constants, types and the arctangent table of the bicycle rollout.
package kbr_pkg;

  localparam int unsigned HorizonStepsDef = 32;
  localparam int unsigned CordicItersDef  = 16;

  localparam int unsigned NumRegs  = 6;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned DataW    = 32;

  // Register indexes
  localparam logic [IdxW-1:0] RegStartX   = 3'd0;
  localparam logic [IdxW-1:0] RegStartY   = 3'd1;
  localparam logic [IdxW-1:0] RegStartPsi = 3'd2;
  localparam logic [IdxW-1:0] RegStartV   = 3'd3;
  localparam logic [IdxW-1:0] RegDt       = 3'd4;
  localparam logic [IdxW-1:0] RegInvL     = 3'd5;

  localparam logic [15:0] DtReset   = 16'd3277;
  localparam logic [15:0] InvLReset = 16'd24545;

  // Angle constants in Q16
  localparam logic [19:0] TwoPi  = 20'd411775;
  localparam logic [19:0] Pi     = 20'd205887;
  localparam logic [19:0] HalfPi = 20'd102944;
  localparam logic [3:0]  ModTopShift = 4'd13;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Serial multiplier widths
  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 34;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned MulNW = 6;

  typedef struct packed {
    logic             start;
    logic [MulNW-1:0] nbits;
  } mul_req_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/kbr_in_if.sv =====
// Input channel: one step's steering and acceleration command.
interface kbr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_angle;
  logic signed [17:0] accel;
  logic               start_req;

  modport source(output valid, steer_angle, accel, start_req, input ready);
  modport sink(input valid, steer_angle, accel, start_req, output ready);
endinterface

// ===== design/kbr_out_if.sv =====
// Output channel: predicted pose after one step.
interface kbr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] speed;
  logic               horizon_end;
  logic               saturated;

  modport source(output valid, pos_x, pos_y, heading, speed, horizon_end, saturated,
                 input ready);
  modport sink(input valid, pos_x, pos_y, heading, speed, horizon_end, saturated,
               output ready);
endinterface

// ===== design/kbr_smul.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module kbr_smul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kbr_pkg::mul_req_t                   req_i,
  input  logic signed [kbr_pkg::MulAW-1:0]    a_i,
  input  logic signed [kbr_pkg::MulBW-1:0]    b_i,
  output logic                                done_o,
  output logic signed [kbr_pkg::MulPW-1:0]    prod_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [kbr_pkg::MulNW-1:0]          cnt_q, cnt_d, nb_q, nb_d;
  logic signed [kbr_pkg::MulPW-1:0]   acc_q, acc_d, ash_q, ash_d;
  logic [kbr_pkg::MulBW-1:0]          b_q, b_d;
  logic                               last;

  assign last = (cnt_q == nb_q - kbr_pkg::MulNW'(1));

  // Advance one bit of the multiplier; the top bit carries negative weight
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nb_d   = nb_q;
    acc_d  = acc_q;
    ash_d  = ash_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      nb_d   = req_i.nbits;
      acc_d  = '0;
      ash_d  = kbr_pkg::MulPW'(a_i);
      b_d    = b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = last ? acc_q - ash_q : acc_q + ash_q;
      end
      ash_d = ash_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + kbr_pkg::MulNW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nb_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      nb_q   <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== design/kinematic_bicycle_rollout.sv =====
// Top level of the kinematic bicycle rollout: one forward-Euler pose step per item.
//
// Each item is accepted in the idle state, then the heading is reduced
// modulo 2*pi (one restoring subtract a cycle), fixed up and rotated by
// CORDIC_ITERS CORDIC iterations, then eight products run on one
// bit-serial multiplier that consumes one multiplier bit a cycle
// (34+17+34+17+16+17+17+17 bits, with a handoff for each). The sum and
// clip are combinational; their result is registered in the cycle in
// which the last product finishes, as long as the output register is free;
// while it still holds an untaken pose, the item waits in its last state.
// One item is worked on at a time; the finished pose sits in an output
// register, so the next item is taken while it waits. A set start_req
// reloads the pose from the start registers before its step and clears the
// step counter.
module kinematic_bicycle_rollout #(
  parameter int unsigned HORIZON_STEPS = kbr_pkg::HorizonStepsDef,
  parameter int unsigned CORDIC_ITERS  = kbr_pkg::CordicItersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kbr_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [kbr_pkg::DataW-1:0]    cfg_data_i,
  kbr_in_if.sink                       in_ch,
  kbr_out_if.source                    out_ch
);

  localparam int unsigned SW = (HORIZON_STEPS > 1) ? $clog2(HORIZON_STEPS) : 1;
  localparam int unsigned IW = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam int unsigned AW = kbr_pkg::MulAW;
  localparam int unsigned BW = kbr_pkg::MulBW;
  localparam int unsigned PW = kbr_pkg::MulPW;

  // Signed angle constants for the fold into [-pi/2, pi/2]
  localparam logic signed [20:0] TwoPiS  = 21'(kbr_pkg::TwoPi);
  localparam logic signed [20:0] PiS     = 21'(kbr_pkg::Pi);
  localparam logic signed [20:0] HalfPiS = 21'(kbr_pkg::HalfPi);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_FIX  = 6'b000100,
    S_CORD = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [31:0] sx_q, sy_q, spsi_q, sv_q;
  logic [15:0]        dt_q, invl_q;

  // Pose and step
  logic signed [31:0] cx_q, cy_q, cpsi_q, cv_q;
  logic [SW-1:0]      step_q;

  // Item operands and intermediates
  logic signed [15:0] delta_q;
  logic signed [17:0] accel_q;
  logic [31:0]        rem_q;
  logic               neg_q;
  logic [3:0]         k_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic               flip_q;
  logic [IW-1:0]      it_q;
  logic [2:0]         op_q;
  logic               issued_q;
  logic signed [AW-1:0] t_q, dx_q, dy_q, dpsi_q;

  // Output register
  logic               ov_q;
  logic signed [31:0] ox_q, oy_q, opsi_q, ovv_q;
  logic               oend_q, osat_q;

  logic accept;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE);

  // Write configuration; out-of-range indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      spsi_q <= '0;
      sv_q   <= '0;
      dt_q   <= kbr_pkg::DtReset;
      invl_q <= kbr_pkg::InvLReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kbr_pkg::RegStartX:   sx_q   <= cfg_data_i;
        kbr_pkg::RegStartY:   sy_q   <= cfg_data_i;
        kbr_pkg::RegStartPsi: spsi_q <= cfg_data_i;
        kbr_pkg::RegStartV:   sv_q   <= cfg_data_i;
        kbr_pkg::RegDt:       dt_q   <= cfg_data_i[15:0];
        kbr_pkg::RegInvL:     invl_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Serial multiplier and its operand select
  kbr_pkg::mul_req_t  mreq;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic                 mdone;
  logic signed [PW-1:0] mprod;
  logic signed [AW-1:0] mres;
  logic signed [BW-1:0] bdt;

  assign bdt = BW'({1'b0, dt_q});

  always_comb begin
    ma         = AW'(cv_q);
    mb         = bdt;
    mreq.nbits = kbr_pkg::MulNW'(17);
    mres       = mprod[16 +: AW];
    unique case (op_q)
      3'd0: begin mb = x_q; mreq.nbits = kbr_pkg::MulNW'(BW); mres = mprod[30 +: AW]; end
      3'd1: begin ma = t_q; end
      3'd2: begin mb = y_q; mreq.nbits = kbr_pkg::MulNW'(BW); mres = mprod[30 +: AW]; end
      3'd3: begin ma = t_q; end
      3'd4: begin mb = BW'(delta_q); mreq.nbits = kbr_pkg::MulNW'(16); end
      3'd5: begin ma = t_q; mb = BW'({1'b0, invl_q}); end
      3'd6: begin ma = t_q; end
      3'd7: begin ma = AW'(accel_q); end
      default: ;
    endcase
    mreq.start = (state_q == S_MUL || state_q == S_OUT) && !issued_q;
  end

  kbr_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mdone),
    .prod_o (mprod)
  );

  // Reduction step, fix-up and CORDIC datapath
  logic [32:0]        sub;
  logic [32:0]        trial;
  logic signed [20:0] r0, r1, r2;
  logic               fl;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  logic               last_it;

  assign sub     = 33'(kbr_pkg::TwoPi) << k_q;
  assign trial   = {1'b0, rem_q} - sub;
  assign xs      = x_q >>> it_q;
  assign ys      = y_q >>> it_q;
  assign at      = 33'(kbr_pkg::atan_q30(5'(it_q)));
  assign last_it = (it_q == IW'(CORDIC_ITERS - 1));

  always_comb begin
    r0 = (neg_q && rem_q != '0) ? TwoPiS - 21'(rem_q) : 21'(rem_q);
    r1 = (r0 > PiS) ? r0 - TwoPiS : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > HalfPiS) begin
      r2 = r1 - PiS;
      fl = 1'b1;
    end else if (r1 < -HalfPiS) begin
      r2 = r1 + PiS;
      fl = 1'b1;
    end
  end

  // Sum and clip the new pose
  logic signed [35:0] sumx, sumy, sump, sumv;
  logic signed [31:0] nx, ny, np, nv;
  logic               sat_any;
  logic               out_free;
  logic               last_step;

  function automatic logic signed [31:0] clip(input logic signed [35:0] s);
    logic signed [31:0] r;
    if (s > 36'sh07FFFFFFF)      r = 32'sh7FFFFFFF;
    else if (s < -36'sh080000000) r = 32'sh80000000;
    else                          r = s[31:0];
    return r;
  endfunction

  assign sumx = 36'(cx_q) + 36'(dx_q);
  assign sumy = 36'(cy_q) + 36'(dy_q);
  assign sump = 36'(cpsi_q) + 36'(dpsi_q);
  assign sumv = 36'(cv_q) + 36'(mres);
  assign nx   = clip(sumx);
  assign ny   = clip(sumy);
  assign np   = clip(sump);
  assign nv   = clip(sumv);
  assign sat_any = (36'(nx) != sumx) || (36'(ny) != sumy)
                || (36'(np) != sump) || (36'(nv) != sumv);
  assign out_free  = !ov_q || out_ch.ready;
  assign last_step = (step_q == SW'(HORIZON_STEPS - 1));

  // Sequence one item
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_MOD;
      S_MOD:  if (k_q == '0) state_d = S_FIX;
      S_FIX:  state_d = S_CORD;
      S_CORD: if (last_it) state_d = S_MUL;
      S_MUL:  if (mdone && op_q == 3'd6) state_d = S_OUT;
      S_OUT:  if (mdone && out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic mdone_hold_q;
  logic mdone_eff;
  logic out_fire;
  assign mdone_eff = mdone || mdone_hold_q;
  assign out_fire  = (state_q == S_OUT) && mdone_eff && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cx_q         <= '0;
      cy_q         <= '0;
      cpsi_q       <= '0;
      cv_q         <= '0;
      step_q       <= '0;
      op_q         <= '0;
      issued_q     <= 1'b0;
      ov_q         <= 1'b0;
      k_q          <= '0;
      it_q         <= '0;
      mdone_hold_q <= 1'b0;
    end else begin
      // Raise valid on a new pose, drop it once taken
      if (out_fire) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.start_req) begin
              cx_q   <= sx_q;
              cy_q   <= sy_q;
              cpsi_q <= spsi_q;
              cv_q   <= sv_q;
              step_q <= '0;
            end
            k_q      <= kbr_pkg::ModTopShift;
            op_q     <= '0;
            issued_q <= 1'b0;
          end
          state_q <= state_d;
        end
        S_MOD: begin
          k_q     <= k_q - 4'd1;
          state_q <= state_d;
        end
        S_FIX: begin
          it_q    <= '0;
          state_q <= state_d;
        end
        S_CORD: begin
          it_q    <= it_q + IW'(1);
          state_q <= state_d;
        end
        S_MUL: begin
          issued_q <= !mdone;
          if (mdone) op_q <= op_q + 3'd1;
          state_q <= state_d;
        end
        S_OUT: begin
          issued_q <= 1'b1;
          if (out_fire) begin
            mdone_hold_q <= 1'b0;
            cx_q   <= nx;
            cy_q   <= ny;
            cpsi_q <= np;
            cv_q   <= nv;
            step_q <= last_step ? '0 : step_q + SW'(1);
            state_q <= S_IDLE;
          end else if (mdone) begin
            mdone_hold_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  logic signed [31:0] h_src;
  assign h_src = in_ch.start_req ? spsi_q : cpsi_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      delta_q <= in_ch.steer_angle;
      accel_q <= in_ch.accel;
      neg_q   <= h_src[31];
      rem_q   <= h_src[31] ? 32'(~h_src) + 32'd1 : h_src;
    end
    if (state_q == S_MOD && !trial[32]) rem_q <= trial[31:0];
    if (state_q == S_FIX) begin
      x_q    <= kbr_pkg::CordicGain;
      y_q    <= '0;
      z_q    <= 33'(r2) <<< 14;
      flip_q <= fl;
    end
    if (state_q == S_CORD) begin
      if (!z_q[32]) begin
        x_q <= last_it && flip_q ? -(x_q - ys) : x_q - ys;
        y_q <= last_it && flip_q ? -(y_q + xs) : y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= last_it && flip_q ? -(x_q + ys) : x_q + ys;
        y_q <= last_it && flip_q ? -(y_q - xs) : y_q - xs;
        z_q <= z_q + at;
      end
    end
    if (state_q == S_MUL && mdone) begin
      unique case (op_q)
        3'd1:    dx_q   <= mres;
        3'd3:    dy_q   <= mres;
        3'd6:    dpsi_q <= mres;
        default: t_q    <= mres;
      endcase
    end
    if (state_q == S_OUT && mdone) t_q <= mres;
    if (out_fire) begin
      ox_q   <= nx;
      oy_q   <= ny;
      opsi_q <= np;
      ovv_q  <= nv;
      oend_q <= last_step;
      osat_q <= sat_any;
    end
  end

  assign out_ch.valid       = ov_q;
  assign out_ch.pos_x       = ox_q;
  assign out_ch.pos_y       = oy_q;
  assign out_ch.heading     = opsi_q;
  assign out_ch.speed       = ovv_q;
  assign out_ch.horizon_end = oend_q;
  assign out_ch.saturated   = osat_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MOD)
    else $error("accepted item did not start reduction");
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> (state_q == S_MUL || state_q == S_OUT))
    else $error("multiplier finished outside the product phase");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= SW'(HORIZON_STEPS - 1))
    else $error("step counter out of horizon");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ch.ready) |=> ov_q && $stable(ox_q))
    else $error("pending result overwritten");
`endif

endmodule

// ===== dv/kbr_test_pkg.sv =====
// Shared item types, codes and the pose predictor for the rollout testbench.
`timescale 1ns / 100ps
package kbr_test_pkg;
  import kbr_pkg::*;

  typedef struct {
    logic signed [15:0] steer;
    logic signed [17:0] accel;
    logic               start;
  } step_cmd_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] psi;
    logic signed [31:0] v;
    logic               last;
    logic               sat;
  } pose_t;

  // What a directed row checks besides the predictor
  typedef enum logic [1:0] {
    ChkModel,
    ChkPose
  } row_chk_e;

  localparam longint TwoPiQ16  = 411775;
  localparam longint PiQ16     = 205887;
  localparam longint HalfPiQ16 = 102944;
  localparam longint GainQ30   = 652032874;

  localparam longint AtanQ30 [0:15] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  // Clip to 32 bits and flag clipping
  function automatic logic signed [31:0] clip32(input longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Reduce the heading and run the rotation; results in Q30
  function automatic void rotate_heading(input logic signed [31:0] psi,
                                         output longint cs, output longint sn);
    longint r, z, cx, cy, nx;
    logic   flip;
    r = longint'(psi) % TwoPiQ16;
    flip = 1'b0;
    if (r < 0) r += TwoPiQ16;
    if (r > PiQ16) r -= TwoPiQ16;
    if (r > HalfPiQ16) begin
      r -= PiQ16;
      flip = 1'b1;
    end else if (r < -HalfPiQ16) begin
      r += PiQ16;
      flip = 1'b1;
    end
    z = r * 16384;
    cx = GainQ30;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= AtanQ30[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += AtanQ30[i];
      end
      cx = nx;
    end
    cs = flip ? -cx : cx;
    sn = flip ? -cy : cy;
  endfunction

  class bicycle_predictor;
    logic [31:0]        regs [NumRegs];
    logic signed [31:0] px, py, ppsi, pv;
    int unsigned        steps;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      regs[RegDt]   = DtReset;
      regs[RegInvL] = InvLReset;
      px = 0; py = 0; ppsi = 0; pv = 0;
      steps = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [31:0] data);
      if (idx < NumRegs) regs[idx] = (idx >= RegDt) ? {16'h0, data[15:0]} : data;
    endfunction

    function pose_t advance(step_cmd_t cmd);
      pose_t  r;
      longint dt, invl, v, cs, sn, dx, dy, dpsi, dv;
      if (cmd.start) begin
        px = regs[RegStartX]; py = regs[RegStartY];
        ppsi = regs[RegStartPsi]; pv = regs[RegStartV];
        steps = 0;
      end
      dt = regs[RegDt][15:0];
      invl = regs[RegInvL][15:0];
      v = pv;
      rotate_heading(ppsi, cs, sn);
      dx = (((v * cs) >>> 30) * dt) >>> 16;
      dy = (((v * sn) >>> 30) * dt) >>> 16;
      dpsi = (((((v * longint'(cmd.steer)) >>> 16) * invl) >>> 16) * dt) >>> 16;
      dv = (longint'(cmd.accel) * dt) >>> 16;
      r.sat = 1'b0;
      r.x = clip32(longint'(px) + dx, r.sat);
      r.y = clip32(longint'(py) + dy, r.sat);
      r.psi = clip32(longint'(ppsi) + dpsi, r.sat);
      r.v = clip32(longint'(pv) + dv, r.sat);
      px = r.x; py = r.y; ppsi = r.psi; pv = r.v;
      r.last = (steps >= HorizonStepsDef - 1);
      steps = r.last ? 0 : steps + 1;
      return r;
    endfunction
  endclass
endpackage

// ===== dv/kinematic_bicycle_rollout_test.sv =====
// Testbench top: drives steps, checks every pose against the predictor.
`timescale 1ns / 100ps
module kinematic_bicycle_rollout_test;
  import kbr_pkg::*;
  import kbr_test_pkg::*;

  localparam int      RandItems  = 950;
  localparam longint  CycleLimit = 1200000;
  localparam int      DrainWait  = 300;
  localparam int      LongHold   = 1000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [IdxW-1:0]  cfg_idx_i;
  logic [DataW-1:0] cfg_data_i;

  kbr_in_if  in_ch ();
  kbr_out_if out_ch ();

  kinematic_bicycle_rollout u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  bicycle_predictor pose_model;
  pose_t            pending_poses [$];
  pose_t            typed_poses [$];
  logic             typed_valid [$];
  int               error_count = 0;
  longint           cycle_count = 0;
  bit               hold_long;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Compare each accepted pose with the oldest expectation
  always @(posedge clk_i) begin
    pose_t exp_p, typ;
    logic  has_typ;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected pose x=%h", $time, out_ch.pos_x);
        error_count++;
      end else begin
        exp_p = pending_poses.pop_front();
        typ = typed_poses.pop_front();
        has_typ = typed_valid.pop_front();
        if ({out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.speed,
             out_ch.horizon_end, out_ch.saturated} !==
            {exp_p.x, exp_p.y, exp_p.psi, exp_p.v, exp_p.last, exp_p.sat}) begin
          $display("%0t: pose mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                   $time, exp_p.x, exp_p.y, exp_p.psi, exp_p.v, exp_p.last, exp_p.sat,
                   out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.speed,
                   out_ch.horizon_end, out_ch.saturated);
          error_count++;
        end
        if (has_typ && {out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.speed,
                        out_ch.saturated} !== {typ.x, typ.y, typ.psi, typ.v, typ.sat})
        begin
          $display("%0t: directed pose mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                   $time, typ.x, typ.y, typ.psi, typ.v, typ.sat, out_ch.pos_x,
                   out_ch.pos_y, out_ch.heading, out_ch.speed, out_ch.saturated);
          error_count++;
        end
      end
    end
  end

  // Stall the receiver on its own pattern, with one long hold-off
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long && !held) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        held = 1'b1;
      end
      mode = (cycle_count / 3000) % 3;
      if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 9) < 3);
    end
  end

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pose_model.write_reg(idx, data);
  endtask

  // Drive one step; inputs change at the falling edge
  task automatic send_step(input step_cmd_t cmd, input bit typed, input pose_t typ);
    pose_t exp_p;
    in_ch.valid <= 1'b1;
    in_ch.steer_angle <= cmd.steer;
    in_ch.accel <= cmd.accel;
    in_ch.start_req <= cmd.start;
    do @(posedge clk_i); while (!in_ch.ready);
    exp_p = pose_model.advance(cmd);
    pending_poses.insert(pending_poses.size(), exp_p);
    typed_poses.insert(typed_poses.size(), typ);
    typed_valid.insert(typed_valid.size(), typed);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic step_cmd_t rand_cmd(input bit start);
    step_cmd_t c;
    c.steer = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                          : 16'($signed($urandom_range(0, 57192)) - 28596);
    c.accel = ($urandom_range(0, 7) == 0) ? 18'($urandom)
                                          : 18'($signed($urandom_range(0, 131072)) - 65536);
    c.start = start;
    return c;
  endfunction

  // Directed rows
  typedef struct {
    step_cmd_t cmd;
    row_chk_e  chk;
    pose_t     pose;
  } step_row_t;

  step_row_t rows [$];
  pose_t     zero_pose;

  initial begin
    step_cmd_t c;
    pose_t     p;
    pose_model = new();
    pose_model.clear();
    hold_long = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.steer_angle = '0;
    in_ch.accel = '0;
    in_ch.start_req = 1'b0;
    zero_pose = '{default: '0};
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // From reset with zero speed: only speed moves by a*dt
    p = zero_pose;
    p.v = 32'sd3277;
    rows.insert(rows.size(), step_row_t'{'{16'sd0, 18'sd65536, 1'b0}, ChkPose, p});
    rows.insert(rows.size(),
                step_row_t'{'{16'sd28596, -18'sd65536, 1'b0}, ChkModel, zero_pose});
    rows.insert(rows.size(),
                step_row_t'{'{-16'sd28596, -18'sd65536, 1'b0}, ChkModel, zero_pose});
    rows.insert(rows.size(),
                step_row_t'{'{16'sh7fff, 18'sh1ffff, 1'b0}, ChkModel, zero_pose});
    rows.insert(rows.size(),
                step_row_t'{'{16'sh8000, 18'sh20000, 1'b0}, ChkModel, zero_pose});
    rows.insert(rows.size(),
                step_row_t'{'{16'shffff, 18'sh3ffff, 1'b1}, ChkModel, zero_pose});
    foreach (rows[i]) begin
      @(negedge clk_i);
      send_step(rows[i].cmd, rows[i].chk == ChkPose, rows[i].pose);
    end
    in_ch.valid <= 1'b0;
    drain();

    // Saturation corner: huge speed at the positive x limit, zero dt
    write_reg(RegStartX, 32'h7fffffff);
    write_reg(RegStartY, 32'h80000000);
    write_reg(RegStartPsi, 32'h7fffffff);
    write_reg(RegStartV, 32'h7fffffff);
    write_reg(RegDt, 32'h0);
    write_reg(RegInvL, 32'hffff);
    write_reg(3'd7, 32'h12345678);
    p.x = 32'sh7fffffff; p.y = 32'sh80000000; p.psi = 32'sh7fffffff;
    p.v = 32'sh7fffffff; p.sat = 1'b0;
    send_step('{16'sd28596, 18'sd65536, 1'b1}, 1'b1, p);
    send_step('{-16'sd28596, -18'sd65536, 1'b0}, 1'b0, p);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(RegDt, 32'hffff);
    for (int i = 0; i < 12; i++) begin
      send_step(rand_cmd(i == 0), 1'b0, zero_pose);
    end
    in_ch.valid <= 1'b0;
    drain();

    // Random phases with several register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegStartX, (ph == 1) ? 32'h80000000 : 32'($urandom));
      write_reg(RegStartY, (ph == 1) ? 32'h7fffffff : 32'($urandom) >>> 8);
      write_reg(RegStartPsi, $urandom);
      write_reg(RegStartV, (ph == 2) ? 32'h80000000 : 32'($signed($urandom) >>> 12));
      write_reg(RegDt, (ph == 3) ? 32'h0 : (ph == 4) ? 32'hffff : $urandom_range(0, 65535));
      write_reg(RegInvL, (ph == 3) ? 32'h0 : $urandom_range(0, 65535));
      if (ph == 2) hold_long = 1'b1;
      for (int n = 0; n < RandItems / 5; ) begin
        int burst;
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && n < RandItems / 5; b++, n++) begin
          c = rand_cmd(n == 0 || $urandom_range(0, 49) == 0);
          send_step(c, 1'b0, zero_pose);
        end
        if ($urandom_range(0, 2) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(negedge clk_i);
        end
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== kinematic_bicycle_rollout.f =====
design/kbr_pkg.sv
design/kbr_in_if.sv
design/kbr_out_if.sv
design/kbr_smul.sv
design/kinematic_bicycle_rollout.sv
dv/kbr_test_pkg.sv
dv/kinematic_bicycle_rollout_test.sv
